// ----- rtl/sld_pkg.sv -----
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants of the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

	localparam logic [7:0] SYNC_BYTE_RESET   = 8'hAA;
	localparam logic [5:0] MAX_PAYLOAD_RESET = 6'd49;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_FUNC,
		PH_LEN,
		PH_DATA,
		PH_CHECK
	} parse_phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SINGLE,
		BK_READ,
		BK_EMIT
	} back_state_t;

	// one finished frame handed from front to back
	typedef struct packed {
		logic [7:0] func;
		logic [5:0] len;
		logic       err;
		logic       bank;
	} frame_cmd_t;

	typedef struct packed {
		logic       en;
		logic       bank;
		logic [5:0] idx;
		logic [7:0] data;
	} payload_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} bank_done_t;

endpackage

// ----- rtl/sld_rx_if.sv -----
// ----------------------------------------------------------------------------
// sld_rx_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface sld_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/sld_res_if.sv -----
// ----------------------------------------------------------------------------
// sld_res_if
// Deframed result channel.
// ----------------------------------------------------------------------------
interface sld_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] func_code;
	logic [5:0] payload_index;
	logic [7:0] payload_byte;
	logic       has_payload;
	logic       frame_status;
	logic       last;

	modport source (output valid, output func_code, output payload_index,
		output payload_byte, output has_payload, output frame_status,
		output last, input ready);
	modport sink (input valid, input func_code, input payload_index,
		input payload_byte, input has_payload, input frame_status,
		input last, output ready);
endinterface

// ----- rtl/sld_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sld_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface sld_cfg_if;
	import sld_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sld_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// sld_cmd_queue
// Two-entry queue of finished frame commands between front and back.
// ----------------------------------------------------------------------------
module sld_cmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sld_pkg::frame_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                avail,
	output sld_pkg::frame_cmd_t head
);
	import sld_pkg::*;

	frame_cmd_t  entry_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (count_q == 2'd2);
	assign avail   = (count_q != 2'd0);
	assign head    = entry_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/sld_front.sv -----
// ----------------------------------------------------------------------------
// sld_front
// Byte parser: sync hunt, header, payload capture and checksum check.
// ----------------------------------------------------------------------------
module sld_front #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sld_rx_if.sink               rx,
	sld_cfg_if.sink              cfg,
	output sld_pkg::payload_wr_t wr,
	output logic                 push,
	output sld_pkg::frame_cmd_t  push_cmd,
	input  logic                 q_full,
	input  sld_pkg::bank_done_t  done
);
	import sld_pkg::*;

	localparam logic [8:0] DEPTH_LIM = 9'(PAYLOAD_DEPTH);

	parse_phase_t phase_q, phase_d;
	logic [5:0]   len_q, len_d;
	logic [5:0]   cnt_q, cnt_d;
	logic [7:0]   sum_q, sum_d;
	logic [7:0]   func_q, func_d;
	logic         bank_q, bank_d;
	logic [1:0]   busy_q, busy_d;
	logic [7:0]   sync_q;
	logic [5:0]   max_q;
	logic         rdy;
	logic         acc;
	logic [7:0]   b;
	logic [5:0]   cnt_inc;

	assign rx.ready  = rdy;
	assign cfg.ready = 1'b1;
	assign b         = rx.rx_byte;
	assign cnt_inc   = cnt_q + 6'd1;

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		func_d  = func_q;
		bank_d  = bank_q;
		busy_d  = busy_q;
		if (done.en) begin
			busy_d[done.bank] = 1'b0;
		end
		wr       = '0;
		push     = 1'b0;
		push_cmd = '{func: func_q, len: len_q, err: (b != sum_q), bank: bank_q};

		// hold data bytes while the back still drains this bank, and the checksum byte while the queue is full
		case (phase_q)
			PH_DATA:  rdy = !busy_q[bank_q];
			PH_CHECK: rdy = !q_full;
			default:  rdy = 1'b1;
		endcase
		acc = rx.valid && rdy;

		if (acc) begin
			case (phase_q)
				PH_SYNC1: begin
					if (b == sync_q) begin
						sum_d   = b;
						phase_d = PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (b == sync_q) begin
						sum_d   = sum_q + b;
						phase_d = PH_FUNC;
					end else begin
						phase_d = PH_SYNC1;
					end
				end
				PH_FUNC: begin
					func_d  = b;
					sum_d   = sum_q + b;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					if ((b > {2'b00, max_q}) || ({1'b0, b} > DEPTH_LIM)) begin
						phase_d = PH_SYNC1;
					end else begin
						len_d   = b[5:0];
						cnt_d   = 6'd0;
						sum_d   = sum_q + b;
						phase_d = (b[5:0] == 6'd0) ? PH_CHECK : PH_DATA;
					end
				end
				PH_DATA: begin
					wr.en   = 1'b1;
					wr.bank = bank_q;
					wr.idx  = cnt_q;
					wr.data = b;
					sum_d   = sum_q + b;
					cnt_d   = cnt_inc;
					if (cnt_inc >= len_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					push = 1'b1;
					// a good frame with payload keeps its bank until drained
					if (!push_cmd.err && (len_q != 6'd0)) begin
						bank_d         = ~bank_q;
						busy_d[bank_q] = 1'b1;
					end
					phase_d = PH_SYNC1;
				end
				default: phase_d = PH_SYNC1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			len_q   <= 6'd0;
			cnt_q   <= 6'd0;
			sum_q   <= 8'd0;
			func_q  <= 8'd0;
			bank_q  <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			func_q  <= func_d;
			bank_q  <= bank_d;
			busy_q  <= busy_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_BYTE_RESET;
			max_q  <= MAX_PAYLOAD_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SYNC_BYTE:   sync_q <= cfg.data;
				CFG_MAX_PAYLOAD: max_q  <= cfg.data[5:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/sld_back.sv -----
// ----------------------------------------------------------------------------
// sld_back
// Payload store and result sequencer: turns frame commands into results.
// ----------------------------------------------------------------------------
module sld_back #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sld_pkg::payload_wr_t wr,
	input  logic                 q_avail,
	input  sld_pkg::frame_cmd_t  q_head,
	output logic                 pop,
	output sld_pkg::bank_done_t  done,
	sld_res_if.source            res
);
	import sld_pkg::*;

	localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

	logic [7:0]  payload_mem_q [2][PAYLOAD_DEPTH];
	logic [7:0]  rdata_q;
	logic [8:0]  wr_wide;
	logic [8:0]  rd_wide;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic        rd_en;

	back_state_t state_q, state_d;
	frame_cmd_t  cmd_q;
	logic [5:0]  idx_q, idx_d;
	logic        load_cmd;
	logic        load_single;
	logic        load_byte;
	logic        slot_free;
	logic        is_last;

	logic        res_valid_q;
	logic [7:0]  out_func_q;
	logic [5:0]  out_idx_q;
	logic [7:0]  out_byte_q;
	logic        out_has_q;
	logic        out_err_q;
	logic        out_last_q;

	assign wr_wide = {3'b000, wr.idx};
	assign rd_wide = {3'b000, idx_q};
	assign waddr   = wr_wide[ADDR_W-1:0];
	assign raddr   = rd_wide[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			payload_mem_q[wr.bank][waddr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= payload_mem_q[cmd_q.bank][raddr];
		end
	end

	assign slot_free = !res_valid_q || res.ready;
	assign is_last   = ((idx_q + 6'd1) == cmd_q.len);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		pop         = 1'b0;
		load_cmd    = 1'b0;
		load_single = 1'b0;
		load_byte   = 1'b0;
		rd_en       = 1'b0;
		done        = '0;
		case (state_q)
			BK_IDLE: begin
				if (q_avail) begin
					pop      = 1'b1;
					load_cmd = 1'b1;
					idx_d    = 6'd0;
					if (!q_head.err && (q_head.len != 6'd0)) begin
						state_d = BK_READ;
					end else begin
						state_d = BK_SINGLE;
					end
				end
			end
			BK_SINGLE: begin
				if (slot_free) begin
					load_single = 1'b1;
					state_d     = BK_IDLE;
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (slot_free) begin
					load_byte = 1'b1;
					if (is_last) begin
						done.en   = 1'b1;
						done.bank = cmd_q.bank;
						state_d   = BK_IDLE;
					end else begin
						idx_d   = idx_q + 6'd1;
						state_d = BK_READ;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= 6'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load_single || load_byte) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cmd_q <= q_head;
		end
		if (load_single) begin
			out_func_q <= cmd_q.func;
			out_idx_q  <= 6'd0;
			out_byte_q <= 8'd0;
			out_has_q  <= 1'b0;
			out_err_q  <= cmd_q.err;
			out_last_q <= 1'b1;
		end else if (load_byte) begin
			out_func_q <= cmd_q.func;
			out_idx_q  <= idx_q;
			out_byte_q <= rdata_q;
			out_has_q  <= 1'b1;
			out_err_q  <= 1'b0;
			out_last_q <= is_last;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.func_code     = out_func_q;
	assign res.payload_index = out_idx_q;
	assign res.payload_byte  = out_byte_q;
	assign res.has_payload   = out_has_q;
	assign res.frame_status  = out_err_q;
	assign res.last          = out_last_q;

endmodule

// ----- rtl/sync_length_checksum_deframer.sv -----
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Takes one received byte per rx item, hunts for two sync bytes, reads a
// function code and a length, stores the payload and checks the trailing
// 8-bit additive checksum. A good frame comes out as one result per payload
// byte (or one empty result for length zero); a bad checksum gives a single
// error result. The parser takes one byte per cycle; it holds a payload byte
// only while the back still drains the older of its two payload banks, and
// holds a checksum byte while the two-entry frame queue is full. The back
// sequencer fetches each frame's command from the queue, then makes each
// payload result by a memory read and an output load, or an empty or error
// result by a single output load; it waits while the output holds a result.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sld_rx_if.sink    rx,
	sld_cfg_if.sink   cfg,
	sld_res_if.source res
);
	import sld_pkg::*;

	payload_wr_t wr;
	frame_cmd_t  push_cmd;
	frame_cmd_t  q_head;
	bank_done_t  done;
	logic        push;
	logic        q_full;
	logic        q_avail;
	logic        pop;

	sld_front #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg      (cfg),
		.wr       (wr),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full),
		.done     (done)
	);

	sld_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	sld_back #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_avail (q_avail),
		.q_head  (q_head),
		.pop     (pop),
		.done    (done),
		.res     (res)
	);

endmodule
